@@ hw/rtl/rvalu_pkg.sv @@
package rvalu_pkg;

  localparam int XLEN         = 32;
  localparam int IDXW         = 5;
  localparam int NUM_REGS_DEF = 32;

  localparam logic REQ_EXEC = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;

  localparam logic [6:0] F7_ALT  = 7'b0100000;
  localparam logic [6:0] F7_BASE = 7'b0000000;

  // ALU funct3
  localparam logic [2:0] F3_ADD  = 3'b000;
  localparam logic [2:0] F3_SLL  = 3'b001;
  localparam logic [2:0] F3_SLT  = 3'b010;
  localparam logic [2:0] F3_SLTU = 3'b011;
  localparam logic [2:0] F3_XOR  = 3'b100;
  localparam logic [2:0] F3_SR   = 3'b101;
  localparam logic [2:0] F3_OR   = 3'b110;
  localparam logic [2:0] F3_AND  = 3'b111;

  // load / store / branch / jalr funct3
  localparam logic [2:0] F3_LB   = 3'b000;
  localparam logic [2:0] F3_LH   = 3'b001;
  localparam logic [2:0] F3_LW   = 3'b010;
  localparam logic [2:0] F3_LBU  = 3'b100;
  localparam logic [2:0] F3_LHU  = 3'b101;
  localparam logic [2:0] F3_SB   = 3'b000;
  localparam logic [2:0] F3_SH   = 3'b001;
  localparam logic [2:0] F3_SW   = 3'b010;
  localparam logic [2:0] F3_BEQ  = 3'b000;
  localparam logic [2:0] F3_BNE  = 3'b001;
  localparam logic [2:0] F3_BLT  = 3'b100;
  localparam logic [2:0] F3_BGE  = 3'b101;
  localparam logic [2:0] F3_BLTU = 3'b110;
  localparam logic [2:0] F3_BGEU = 3'b111;
  localparam logic [2:0] F3_JALR = 3'b000;

  typedef enum logic [1:0] {
    ST_EXEC    = 2'd0,
    ST_DECODED = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  typedef struct packed {
    status_t           status;
    logic              wr_en;
    logic [IDXW-1:0]   didx;
    logic [XLEN-1:0]   dval;
  } exec_res_t;

endpackage

@@ hw/rtl/rvalu_if.sv @@
interface rvalu_req_if;
  import rvalu_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [XLEN-1:0]   instr_word;
  logic [IDXW-1:0]   reg_index;

  modport source (output valid, output req_type, output instr_word, output reg_index,
                  input ready);
  modport sink   (input valid, input req_type, input instr_word, input reg_index,
                  output ready);
endinterface

interface rvalu_rsp_if;
  import rvalu_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              wrote;
  logic [IDXW-1:0]   dest_index;
  logic [XLEN-1:0]   dest_value;
  logic [XLEN-1:0]   read_value;

  modport source (output valid, output status, output wrote, output dest_index,
                  output dest_value, output read_value, input ready);
  modport sink   (input valid, input status, input wrote, input dest_index,
                  input dest_value, input read_value, output ready);
endinterface

@@ hw/rtl/rv32i_alu_execute_regfile_top.sv @@
// Channel  | Dir | Payload                                             | Handshake
// in_if    | in  | req_type, instr_word, reg_index                     | valid/ready
// out_if   | out | status, wrote, dest_index, dest_value, read_value   | valid/ready
//
// One item per cycle while out_if.ready is high; items go execute stage, then output reg.
// Register file reads are registered at acceptance, with same-cycle write bypass.
// A waiting result holds the execute stage; in_if.ready drops once that stage is full too.
// Reset clears pipeline valids and per-register valid bits; unwritten registers read 0.
module rv32i_alu_execute_regfile_top #(
  parameter int NUM_REGS = rvalu_pkg::NUM_REGS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  rvalu_req_if.sink   in_if,
  rvalu_rsp_if.source out_if
);
  import rvalu_pkg::*;

  logic            in_acc;
  logic            s1_go;
  logic            s1_move;
  logic            s1_vld_r;
  logic            s1_vld_nxt;
  logic            s1_req_r;
  logic [XLEN-1:0] s1_instr_r;
  logic            out_vld_r;
  logic            out_vld_nxt;
  logic [1:0]      status_r;
  logic            wrote_r;
  logic [IDXW-1:0] didx_r;
  logic [XLEN-1:0] dval_r;
  logic [XLEN-1:0] rval_r;
  logic [IDXW-1:0] ra_idx;
  logic [XLEN-1:0] a;
  logic [XLEN-1:0] b;
  exec_res_t       res;

  assign s1_go   = !out_vld_r || out_if.ready;
  assign s1_move = s1_vld_r && s1_go;
  assign in_if.ready = !s1_vld_r || s1_go;
  assign in_acc  = in_if.valid && in_if.ready;

  assign ra_idx = (in_if.req_type == REQ_READ) ? in_if.reg_index : in_if.instr_word[19:15];

  rvalu_rf #(.NUM_REGS(NUM_REGS)) u_rf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .ra_idx  (ra_idx),
    .rb_idx  (in_if.instr_word[24:20]),
    .wr_en   (s1_move && res.wr_en),
    .wr_idx  (res.didx),
    .wr_data (res.dval),
    .ra_data (a),
    .rb_data (b)
  );

  rvalu_exec #(.NUM_REGS(NUM_REGS)) u_exec (
    .req_type   (s1_req_r),
    .instr_word (s1_instr_r),
    .a          (a),
    .b          (b),
    .res        (res)
  );

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (s1_move) begin
      out_vld_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r   <= in_if.req_type;
      s1_instr_r <= in_if.instr_word;
    end
    if (s1_move) begin
      status_r <= res.status;
      wrote_r  <= res.wr_en;
      didx_r   <= res.didx;
      dval_r   <= res.dval;
      rval_r   <= (s1_req_r == REQ_READ) ? a : '0;
    end
  end

  assign out_if.valid      = out_vld_r;
  assign out_if.status     = status_r;
  assign out_if.wrote      = wrote_r;
  assign out_if.dest_index = didx_r;
  assign out_if.dest_value = dval_r;
  assign out_if.read_value = rval_r;

endmodule

@@ hw/rtl/rvalu_rf.sv @@
module rvalu_rf #(
  parameter int NUM_REGS = rvalu_pkg::NUM_REGS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [rvalu_pkg::IDXW-1:0] ra_idx,
  input  logic [rvalu_pkg::IDXW-1:0] rb_idx,
  input  logic                       wr_en,
  input  logic [rvalu_pkg::IDXW-1:0] wr_idx,
  input  logic [rvalu_pkg::XLEN-1:0] wr_data,
  output logic [rvalu_pkg::XLEN-1:0] ra_data,
  output logic [rvalu_pkg::XLEN-1:0] rb_data
);
  import rvalu_pkg::*;

  localparam int AW = $clog2(NUM_REGS);
  localparam logic [IDXW:0] NREG = (IDXW+1)'(NUM_REGS);

  logic [XLEN-1:0]     mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  logic [XLEN-1:0]     ra_data_r;
  logic [XLEN-1:0]     rb_data_r;
  logic                ra_ok_r;
  logic                rb_ok_r;
  logic                ra_ok;
  logic                rb_ok;
  logic                ra_byp;
  logic                rb_byp;
  logic                wr_ok;

  // x0 and indexes past the file read as zero
  assign ra_ok  = (ra_idx != '0) && ({1'b0, ra_idx} < NREG);
  assign rb_ok  = (rb_idx != '0) && ({1'b0, rb_idx} < NREG);
  assign wr_ok  = wr_en && ({1'b0, wr_idx} < NREG);
  assign ra_byp = wr_ok && (wr_idx == ra_idx);
  assign rb_byp = wr_ok && (wr_idx == rb_idx);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_idx[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      ra_data_r <= ra_byp ? wr_data : mem[ra_idx[AW-1:0]];
      rb_data_r <= rb_byp ? wr_data : mem[rb_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      ra_ok_r <= 1'b0;
      rb_ok_r <= 1'b0;
    end else begin
      if (wr_ok) begin
        vld_r[wr_idx[AW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        ra_ok_r <= ra_ok && (ra_byp || vld_r[ra_idx[AW-1:0]]);
        rb_ok_r <= rb_ok && (rb_byp || vld_r[rb_idx[AW-1:0]]);
      end
    end
  end

  assign ra_data = ra_ok_r ? ra_data_r : '0;
  assign rb_data = rb_ok_r ? rb_data_r : '0;

endmodule

@@ hw/rtl/rvalu_exec.sv @@
module rvalu_exec #(
  parameter int NUM_REGS = rvalu_pkg::NUM_REGS_DEF
) (
  input  logic                       req_type,
  input  logic [rvalu_pkg::XLEN-1:0] instr_word,
  input  logic [rvalu_pkg::XLEN-1:0] a,
  input  logic [rvalu_pkg::XLEN-1:0] b,
  output rvalu_pkg::exec_res_t       res
);
  import rvalu_pkg::*;

  localparam logic [IDXW:0] NREG = (IDXW+1)'(NUM_REGS);

  logic [6:0]      opc;
  logic [2:0]      f3;
  logic [6:0]      f7;
  logic [IDXW-1:0] rd;
  logic [4:0]      shi;
  logic [XLEN-1:0] imm;
  logic            alt;
  status_t         status;
  logic [XLEN-1:0] val;
  logic            do_wr;

  assign opc = instr_word[6:0];
  assign rd  = instr_word[11:7];
  assign f3  = instr_word[14:12];
  assign shi = instr_word[24:20];
  assign f7  = instr_word[31:25];
  assign imm = {{20{instr_word[31]}}, instr_word[31:20]};
  assign alt = (f7 == F7_ALT);

  always_comb begin
    status = ST_UNKNOWN;
    val    = '0;
    if (req_type == REQ_READ) begin
      status = ST_EXEC;
    end else begin
      unique case (opc)
        OPC_OP: begin
          if (f7 == F7_BASE || f7 == F7_ALT) begin
            status = ST_EXEC;
            case (f3)
              F3_ADD:  val = alt ? a - b : a + b;
              F3_SLL:  val = a << b[4:0];
              F3_SLT:  val = XLEN'($signed(a) < $signed(b));
              F3_SLTU: val = XLEN'(a < b);
              F3_XOR:  val = a ^ b;
              F3_SR:   val = alt ? XLEN'($signed(a) >>> b[4:0]) : a >> b[4:0];
              F3_OR:   val = a | b;
              default: val = a & b;
            endcase
          end
        end
        OPC_OPIMM: begin
          status = ST_EXEC;
          case (f3)
            F3_ADD:  val = a + imm;
            F3_SLL:  val = a << shi;
            F3_SLT:  val = XLEN'($signed(a) < $signed(imm));
            F3_SLTU: val = XLEN'(a < imm);
            F3_XOR:  val = a ^ imm;
            F3_SR: begin
              if (f7 == F7_BASE) begin
                val = a >> shi;
              end else if (f7 == F7_ALT) begin
                val = XLEN'($signed(a) >>> shi);
              end else begin
                status = ST_UNKNOWN;
              end
            end
            F3_OR:   val = a | imm;
            default: val = a & imm;
          endcase
        end
        OPC_LUI: begin
          status = ST_EXEC;
          val    = {instr_word[31:12], 12'b0};
        end
        OPC_LOAD: begin
          status = (f3 == F3_LB || f3 == F3_LH || f3 == F3_LW || f3 == F3_LBU ||
                    f3 == F3_LHU) ? ST_DECODED : ST_UNKNOWN;
        end
        OPC_STORE: begin
          status = (f3 == F3_SB || f3 == F3_SH || f3 == F3_SW) ? ST_DECODED : ST_UNKNOWN;
        end
        OPC_BRANCH: begin
          status = (f3 == F3_BEQ || f3 == F3_BNE || f3 == F3_BLT || f3 == F3_BGE ||
                    f3 == F3_BLTU || f3 == F3_BGEU) ? ST_DECODED : ST_UNKNOWN;
        end
        OPC_JALR: begin
          status = (f3 == F3_JALR) ? ST_DECODED : ST_UNKNOWN;
        end
        OPC_JAL, OPC_AUIPC: begin
          status = ST_DECODED;
        end
        default: begin
          status = ST_UNKNOWN;
        end
      endcase
    end
  end

  assign do_wr = (req_type == REQ_EXEC) && (status == ST_EXEC) && (rd != '0);

  always_comb begin
    res.status = status;
    res.didx   = do_wr ? rd : '0;
    res.wr_en  = do_wr && ({1'b0, rd} < NREG);
    res.dval   = res.wr_en ? val : '0;
  end

endmodule

@@ dv/tb_rv32i_alu_execute_regfile_top.sv @@
module tb_rv32i_alu_execute_regfile_top;
  import rvalu_pkg::*;

  localparam int NREGS      = NUM_REGS_DEF;
  localparam int N_RANDOM   = 1820;
  localparam int QUIET_TAIL = 200;
  localparam int HOLD_AT    = 700;
  localparam int HOLD_LEN   = 120;
  localparam int PAUSE_AT   = 1200;
  localparam int WDOG_LIMIT = 2000;
  localparam int MAX_SHOWN  = 10;

  typedef struct packed {
    logic            req_type;
    logic [XLEN-1:0] instr_word;
    logic [IDXW-1:0] reg_index;
  } alu_req_t;

  typedef struct packed {
    status_t         status;
    logic            wrote;
    logic [IDXW-1:0] dest_index;
    logic [XLEN-1:0] dest_value;
    logic [XLEN-1:0] read_value;
  } alu_rsp_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rvalu_req_if in_if ();
  rvalu_rsp_if out_if ();

  rv32i_alu_execute_regfile_top #(.NUM_REGS(NREGS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always #5 clk = ~clk;

  alu_req_t        instr_q[$];
  alu_rsp_t        retired_q[$];
  logic [XLEN-1:0] gpr[NREGS];
  int              n_items;
  int              n_acc;
  int              n_err;
  int              gap_left;
  int              stall_left;
  int              hold_left;
  bit              hold_done;
  int              idle_cnt;

  function automatic logic [XLEN-1:0] gpr_rd(logic [IDXW-1:0] i);
    return (i == 0 || i >= NREGS) ? '0 : gpr[i];
  endfunction

  function automatic logic [XLEN-1:0] shr_arith(logic [XLEN-1:0] v, logic [4:0] sh);
    logic signed [XLEN-1:0] s;
    s = v;
    return s >>> sh;
  endfunction

  function automatic alu_rsp_t retire_instr(alu_req_t r);
    logic [6:0]      opc;
    logic [6:0]      f7;
    logic [2:0]      f3;
    logic [4:0]      rd;
    logic [4:0]      rs1;
    logic [4:0]      rs2;
    logic [XLEN-1:0] imm;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] res;
    alu_rsp_t        o;
    opc = r.instr_word[6:0];
    rd  = r.instr_word[11:7];
    f3  = r.instr_word[14:12];
    rs1 = r.instr_word[19:15];
    rs2 = r.instr_word[24:20];
    f7  = r.instr_word[31:25];
    imm = {{20{r.instr_word[31]}}, r.instr_word[31:20]};
    a   = gpr_rd(rs1);
    b   = gpr_rd(rs2);
    res = '0;
    o   = '0;
    o.status = ST_UNKNOWN;
    if (r.req_type == REQ_READ) begin
      o.status     = ST_EXEC;
      o.read_value = gpr_rd(r.reg_index);
    end else begin
      case (opc)
        OPC_OP: begin
          if (f7 == F7_BASE || f7 == F7_ALT) begin
            o.status = ST_EXEC;
            case (f3)
              F3_ADD:  res = (f7 == F7_ALT) ? a - b : a + b;
              F3_SLL:  res = a << b[4:0];
              F3_SLT:  res = {31'b0, $signed(a) < $signed(b)};
              F3_SLTU: res = {31'b0, a < b};
              F3_XOR:  res = a ^ b;
              F3_SR: begin
                if (f7 == F7_ALT) res = shr_arith(a, b[4:0]);
                else res = a >> b[4:0];
              end
              F3_OR:   res = a | b;
              default: res = a & b;
            endcase
          end
        end
        OPC_OPIMM: begin
          o.status = ST_EXEC;
          case (f3)
            F3_ADD:  res = a + imm;
            F3_SLL:  res = a << rs2;
            F3_SLT:  res = {31'b0, $signed(a) < $signed(imm)};
            F3_SLTU: res = {31'b0, a < imm};
            F3_XOR:  res = a ^ imm;
            F3_SR: begin
              if (f7 == F7_BASE) res = a >> rs2;
              else if (f7 == F7_ALT) res = shr_arith(a, rs2);
              else o.status = ST_UNKNOWN;
            end
            F3_OR:   res = a | imm;
            default: res = a & imm;
          endcase
        end
        OPC_LUI: begin
          o.status = ST_EXEC;
          res = {r.instr_word[31:12], 12'b0};
        end
        OPC_LOAD:
          o.status = (f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU}) ? ST_DECODED : ST_UNKNOWN;
        OPC_STORE:
          o.status = (f3 inside {F3_SB, F3_SH, F3_SW}) ? ST_DECODED : ST_UNKNOWN;
        OPC_BRANCH:
          o.status = (f3 inside {F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU}) ?
                     ST_DECODED : ST_UNKNOWN;
        OPC_JALR:
          o.status = (f3 == F3_JALR) ? ST_DECODED : ST_UNKNOWN;
        OPC_JAL, OPC_AUIPC:
          o.status = ST_DECODED;
        default:
          o.status = ST_UNKNOWN;
      endcase
      if (o.status == ST_EXEC && rd != 0) begin
        o.dest_index = rd;
        if (rd < NREGS) begin
          gpr[rd]      = res;
          o.wrote      = 1'b1;
          o.dest_value = res;
        end
      end
    end
    return o;
  endfunction

  function automatic logic [31:0] enc(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                      logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  task automatic push_exec(logic [31:0] w);
    alu_req_t r;
    r.req_type   = REQ_EXEC;
    r.instr_word = w;
    r.reg_index  = 5'($urandom);
    instr_q.push_back(r);
  endtask

  task automatic push_read(logic [4:0] idx);
    alu_req_t r;
    r.req_type   = REQ_READ;
    r.instr_word = $urandom;
    r.reg_index  = idx;
    instr_q.push_back(r);
  endtask

  task automatic push_random();
    int unsigned pick;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [11:0] imm12;
    logic [31:0] w;
    alu_req_t    r;
    pick = $urandom_range(0, 99);
    f7   = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
    if ($urandom_range(0, 9) == 0) f7 = 7'($urandom);
    f3  = 3'($urandom);
    rd  = 5'($urandom);
    rs1 = 5'($urandom);
    rs2 = 5'($urandom);
    case ($urandom_range(0, 5))
      0:       imm12 = 12'h7ff;
      1:       imm12 = 12'h800;
      2:       imm12 = 12'hfff;
      3:       imm12 = 12'h000;
      default: imm12 = 12'($urandom);
    endcase
    if (pick < 34) begin
      push_exec(enc(f7, rs2, rs1, f3, rd, OPC_OP));
    end else if (pick < 64) begin
      if (f3 == F3_SLL) f7 = 7'($urandom);
      else if (f3 != F3_SR) {f7, rs2} = imm12;
      push_exec(enc(f7, rs2, rs1, f3, rd, OPC_OPIMM));
    end else if (pick < 72) begin
      push_exec({20'($urandom), rd, OPC_LUI});
    end else if (pick < 84) begin
      push_read(5'($urandom));
    end else if (pick < 95) begin
      w = $urandom;
      case ($urandom_range(0, 5))
        0:       w[6:0] = OPC_LOAD;
        1:       w[6:0] = OPC_STORE;
        2:       w[6:0] = OPC_BRANCH;
        3:       w[6:0] = OPC_JAL;
        4:       w[6:0] = OPC_JALR;
        default: w[6:0] = OPC_AUIPC;
      endcase
      push_exec(w);
    end else begin
      r.req_type   = 1'($urandom);
      r.instr_word = $urandom;
      r.reg_index  = 5'($urandom);
      instr_q.push_back(r);
    end
  endtask

  // driver
  always @(posedge clk) begin
    alu_req_t acc;
    alu_req_t nxt;
    bit       quiet;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        acc.req_type   = in_if.req_type;
        acc.instr_word = in_if.instr_word;
        acc.reg_index  = in_if.reg_index;
        retired_q.push_back(retire_instr(acc));
        n_acc++;
      end
      if (!in_if.valid || in_if.ready) begin
        quiet = (n_acc + QUIET_TAIL >= n_items) || ((n_acc / 250) % 3 == 2);
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if ((n_acc == PAUSE_AT && retired_q.size() != 0) || instr_q.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 8);
          in_if.valid <= 1'b0;
        end else begin
          nxt = instr_q.pop_front();
          in_if.valid      <= 1'b1;
          in_if.req_type   <= nxt.req_type;
          in_if.instr_word <= nxt.instr_word;
          in_if.reg_index  <= nxt.reg_index;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    alu_rsp_t want;
    alu_rsp_t got;
    bit       quiet;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.status     = status_t'(out_if.status);
        got.wrote      = out_if.wrote;
        got.dest_index = out_if.dest_index;
        got.dest_value = out_if.dest_value;
        got.read_value = out_if.read_value;
        if (retired_q.size() == 0) begin
          n_err++;
          if (n_err <= MAX_SHOWN)
            $display("unexpected item: status=%0d wrote=%0d rd=%0d dval=%h rval=%h",
                     got.status, got.wrote, got.dest_index, got.dest_value, got.read_value);
        end else begin
          want = retired_q.pop_front();
          if (got.status !== want.status || got.wrote !== want.wrote ||
              got.dest_index !== want.dest_index || got.dest_value !== want.dest_value ||
              got.read_value !== want.read_value) begin
            n_err++;
            if (n_err <= MAX_SHOWN) begin
              $display("mismatch: exp status=%0d wrote=%0d rd=%0d dval=%h rval=%h",
                       want.status, want.wrote, want.dest_index, want.dest_value,
                       want.read_value);
              $display("          got status=%0d wrote=%0d rd=%0d dval=%h rval=%h",
                       got.status, got.wrote, got.dest_index, got.dest_value,
                       got.read_value);
            end
          end
        end
      end
      if (!hold_done && n_acc >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      quiet = (n_acc + QUIET_TAIL >= n_items) || ((n_acc / 250) % 3 == 1);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WDOG_LIMIT) begin
      $display("tb_rv32i_alu_execute_regfile_top NOT OK");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.req_type   = REQ_EXEC;
    in_if.instr_word = '0;
    in_if.reg_index  = '0;
    out_if.ready     = 1'b0;
    for (int i = 0; i < NREGS; i++) gpr[i] = '0;

    // directed: extremes, every ALU op, x0 write, decode-only and unknown encodings
    push_read(5'd0);
    push_exec(enc(7'h7f, 5'h1f, 5'h1f, 3'h7, 5'd1, OPC_LUI));
    push_exec(enc(7'h40, 5'd0, 5'd0, 3'h0, 5'd2, OPC_LUI));
    push_exec(enc(7'h7f, 5'h1f, 5'd0, F3_ADD, 5'd3, OPC_OPIMM));
    push_exec(enc(7'h3f, 5'h1f, 5'd0, F3_ADD, 5'd4, OPC_OPIMM));
    push_exec(enc(F7_BASE, 5'd3, 5'd2, F3_ADD, 5'd5, OPC_OP));
    push_exec(enc(F7_ALT, 5'd4, 5'd2, F3_ADD, 5'd6, OPC_OP));
    push_exec(enc(F7_BASE, 5'd4, 5'd3, F3_SLL, 5'd7, OPC_OP));
    push_exec(enc(F7_ALT, 5'd5, 5'd2, F3_SLT, 5'd8, OPC_OP));
    push_exec(enc(F7_BASE, 5'd2, 5'd5, F3_SLTU, 5'd9, OPC_OP));
    push_exec(enc(F7_ALT, 5'd5, 5'd1, F3_XOR, 5'd10, OPC_OP));
    push_exec(enc(F7_BASE, 5'd4, 5'd2, F3_SR, 5'd11, OPC_OP));
    push_exec(enc(F7_ALT, 5'd4, 5'd2, F3_SR, 5'd12, OPC_OP));
    push_exec(enc(F7_ALT, 5'd4, 5'd2, F3_OR, 5'd13, OPC_OP));
    push_exec(enc(F7_BASE, 5'd5, 5'd3, F3_AND, 5'd14, OPC_OP));
    push_exec(enc(7'h01, 5'd5, 5'd3, F3_ADD, 5'd15, OPC_OP));
    push_exec(enc(7'h40, 5'd0, 5'd2, F3_SLT, 5'd15, OPC_OPIMM));
    push_exec(enc(7'h7f, 5'h1f, 5'd4, F3_SLTU, 5'd16, OPC_OPIMM));
    push_exec(enc(7'h2a, 5'h15, 5'd3, F3_XOR, 5'd17, OPC_OPIMM));
    push_exec(enc(7'h3f, 5'h1f, 5'd2, F3_OR, 5'd18, OPC_OPIMM));
    push_exec(enc(7'h40, 5'd0, 5'd3, F3_AND, 5'd19, OPC_OPIMM));
    push_exec(enc(7'h7f, 5'h1f, 5'd3, F3_SLL, 5'd20, OPC_OPIMM));
    push_exec(enc(F7_BASE, 5'd1, 5'd2, F3_SR, 5'd21, OPC_OPIMM));
    push_exec(enc(F7_ALT, 5'h1f, 5'd2, F3_SR, 5'd22, OPC_OPIMM));
    push_exec(enc(7'h10, 5'd1, 5'd2, F3_SR, 5'd23, OPC_OPIMM));
    push_exec(enc(F7_BASE, 5'd3, 5'd3, F3_ADD, 5'd0, OPC_OP));
    push_exec(enc(7'h00, 5'd0, 5'd1, F3_LW, 5'd24, OPC_LOAD));
    push_exec(enc(7'h00, 5'd0, 5'd1, 3'b111, 5'd24, OPC_LOAD));
    push_exec(enc(7'h00, 5'd2, 5'd1, 3'b011, 5'd0, OPC_STORE));
    push_exec(enc(7'h00, 5'd2, 5'd1, 3'b010, 5'd0, OPC_BRANCH));
    push_exec(enc(7'h00, 5'd0, 5'd1, 3'b001, 5'd25, OPC_JALR));
    push_exec(enc(7'h7f, 5'h1f, 5'h1f, 3'h7, 5'd26, OPC_JAL));
    push_exec(enc(7'h12, 5'd3, 5'd4, 3'h5, 5'd27, OPC_AUIPC));
    push_exec(32'hffff_ffff);
    push_read(5'd22);
    push_read(5'd31);

    for (int i = 0; i < N_RANDOM; i++) push_random();
    n_items = instr_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (n_acc < n_items || retired_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_err == 0) begin
      $display("tb_rv32i_alu_execute_regfile_top OK");
    end else begin
      $display("tb_rv32i_alu_execute_regfile_top NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/rvalu_pkg.sv
hw/rtl/rvalu_if.sv
hw/rtl/rvalu_rf.sv
hw/rtl/rvalu_exec.sv
hw/rtl/rv32i_alu_execute_regfile_top.sv
dv/tb_rv32i_alu_execute_regfile_top.sv
